/* hw/rtl/sag_pkg.sv */
// Shared types and constants for the strided address generator
// No dependencies; used by every module in hw/rtl
package sag_pkg;

    // packed slots in the extent and stride words, dimension 0 in the top bits
    localparam int SLOTS = 4;
    localparam int EXT_W = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_DIM_COUNT  = 3'd1;
    localparam logic [2:0] CFG_EXTENTS    = 3'd2;
    localparam logic [2:0] CFG_STRIDES    = 3'd3;
    localparam logic [2:0] CFG_BASE       = 3'd4;
    localparam logic [2:0] CFG_FILL       = 3'd5;

    // modes
    localparam logic [1:0] MODE_GATHER  = 2'd0;
    localparam logic [1:0] MODE_SCATTER = 2'd1;
    localparam logic [1:0] MODE_FILL    = 2'd2;

    // reset values
    localparam logic [1:0]  RST_MODE      = MODE_GATHER;
    localparam logic [2:0]  RST_DIM_COUNT = 3'd1;
    localparam logic [63:0] RST_EXTENTS   = 64'h0001_0001_0001_0001;
    localparam logic [63:0] RST_STRIDES   = 64'h0;
    localparam logic [31:0] RST_BASE      = 32'h0;
    localparam logic [31:0] RST_FILL      = 32'h0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  dim_count;
        logic [63:0] extent_words;
        logic [63:0] stride_words;
        logic [31:0] base_offset;
        logic [31:0] fill_value;
    } t_cfg;

    typedef struct packed {
        logic        restart;
        logic [31:0] data_in;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] strided_address;
        logic [31:0] linear_index;
        logic [31:0] write_value;
        logic        last;
        logic        address_overflow;
    } t_out_beat;

    // pipeline stage controls
    typedef struct packed {
        logic accept;
        logic load1;
        logic load2;
        logic load3;
    } t_adv;

endpackage

/* hw/rtl/sag_walk.sv */
// Position counters, element count and the input stage register
// Depends on sag_pkg
module sag_walk #(
    parameter int MAX_DIMS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sag_pkg::t_cfg     i_cfg,
    input  sag_pkg::t_adv     i_adv,
    input  sag_pkg::t_in_beat i_beat,
    output logic [15:0]       o_pos [MAX_DIMS < sag_pkg::SLOTS ? MAX_DIMS : sag_pkg::SLOTS],
    output logic [(MAX_DIMS < sag_pkg::SLOTS ? MAX_DIMS : sag_pkg::SLOTS)-1:0] o_in_use,
    output logic [31:0]       o_index,
    output logic [31:0]       o_wval,
    output logic              o_last
);

    localparam int NUM_SLOTS = MAX_DIMS < sag_pkg::SLOTS ? MAX_DIMS : sag_pkg::SLOTS;

    logic [15:0]          r_pos [NUM_SLOTS];
    logic [15:0]          n_pos [NUM_SLOTS];
    logic [31:0]          r_count;
    logic [31:0]          n_count;
    logic [15:0]          pos_eff [NUM_SLOTS];
    logic [31:0]          count_eff;
    logic [NUM_SLOTS-1:0] in_use;
    logic [NUM_SLOTS-1:0] at_end;
    logic [3:0]           dims;
    logic                 wrap;

    // stage one payload
    logic [15:0]          r_s1_pos [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_s1_in_use;
    logic [31:0]          r_s1_index;
    logic [31:0]          r_s1_wval;
    logic                 r_s1_last;

    always_comb begin
        logic [15:0] ext;
        logic        c;
        dims = {1'b0, i_cfg.dim_count};
        if (dims == 4'd0) begin
            dims = 4'd1;
        end else if (dims > 4'(NUM_SLOTS)) begin
            dims = 4'(NUM_SLOTS);
        end
        count_eff = i_beat.restart ? 32'd0 : r_count;
        for (int d = 0; d < NUM_SLOTS; d++) begin
            pos_eff[d] = i_beat.restart ? 16'd0 : r_pos[d];
            in_use[d]  = 4'(d) < dims;
            ext        = i_cfg.extent_words[(sag_pkg::SLOTS - 1 - d) * sag_pkg::EXT_W +: 16];
            // zero extent counts as one, so the counter is always at its end
            at_end[d]  = (ext == 16'd0) || (pos_eff[d] >= ext - 16'd1);
        end
        // innermost dimension counts fastest, carry ripples outward
        c = 1'b1;
        for (int d = NUM_SLOTS - 1; d >= 0; d--) begin
            n_pos[d] = pos_eff[d];
            if (in_use[d] && c) begin
                n_pos[d] = at_end[d] ? 16'd0 : pos_eff[d] + 16'd1;
                c        = at_end[d];
            end
        end
        wrap = c;
        if (wrap) begin
            for (int d = 0; d < NUM_SLOTS; d++) begin
                n_pos[d] = 16'd0;
            end
            n_count = 32'd0;
        end else begin
            n_count = count_eff + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_SLOTS; d++) begin
                r_pos[d] <= 16'd0;
            end
            r_count <= 32'd0;
        end else if (i_adv.accept) begin
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.load1) begin
            r_s1_pos    <= pos_eff;
            r_s1_in_use <= in_use;
            r_s1_index  <= count_eff;
            r_s1_wval   <= (i_cfg.mode == sag_pkg::MODE_FILL) ? i_cfg.fill_value
                                                              : i_beat.data_in;
            r_s1_last   <= wrap;
        end
    end

    assign o_pos    = r_s1_pos;
    assign o_in_use = r_s1_in_use;
    assign o_index  = r_s1_index;
    assign o_wval   = r_s1_wval;
    assign o_last   = r_s1_last;

endmodule

/* hw/rtl/sag_addr.sv */
// Address datapath: stride products, then offset sum and overflow into the output register
// Depends on sag_pkg
module sag_addr #(
    parameter int MAX_DIMS   = 4,
    parameter int ADDR_WIDTH = 32
) (
    input  logic               i_clk,
    input  sag_pkg::t_cfg      i_cfg,
    input  sag_pkg::t_adv      i_adv,
    input  logic [15:0]        i_pos [MAX_DIMS < sag_pkg::SLOTS ? MAX_DIMS : sag_pkg::SLOTS],
    input  logic [(MAX_DIMS < sag_pkg::SLOTS ? MAX_DIMS : sag_pkg::SLOTS)-1:0] i_in_use,
    input  logic [31:0]        i_index,
    input  logic [31:0]        i_wval,
    input  logic               i_last,
    output sag_pkg::t_out_beat o_beat
);

    localparam int NUM_SLOTS = MAX_DIMS < sag_pkg::SLOTS ? MAX_DIMS : sag_pkg::SLOTS;
    localparam int AW        = ADDR_WIDTH < 32 ? ADDR_WIDTH : 32;
    localparam int SUM_W     = 32 + $clog2(NUM_SLOTS + 1);

    logic [31:0]        r_prod [NUM_SLOTS];
    logic [31:0]        r_s2_index;
    logic [31:0]        r_s2_wval;
    logic               r_s2_last;
    logic [SUM_W-1:0]   sum;
    sag_pkg::t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (i_adv.load2) begin
            for (int d = 0; d < NUM_SLOTS; d++) begin
                r_prod[d] <= i_in_use[d]
                    ? i_cfg.stride_words[(sag_pkg::SLOTS - 1 - d) * sag_pkg::EXT_W +: 16]
                      * i_pos[d]
                    : 32'd0;
            end
            r_s2_index <= i_index;
            r_s2_wval  <= i_wval;
            r_s2_last  <= i_last;
        end
    end

    always_comb begin
        sum = SUM_W'(i_cfg.base_offset);
        for (int d = 0; d < NUM_SLOTS; d++) begin
            sum = sum + SUM_W'(r_prod[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.load3) begin
            r_out.strided_address  <= 32'(sum[AW-1:0]);
            r_out.linear_index     <= r_s2_index;
            r_out.write_value      <= r_s2_wval;
            r_out.last             <= r_s2_last;
            r_out.address_overflow <= |sum[SUM_W-1:AW];
        end
    end

    assign o_beat = r_out;

endmodule

/* hw/rtl/strided_address_generator.sv */
// Strided N-dimensional address generator, top level: config registers, stage handshake
// Depends on sag_pkg, sag_walk, sag_addr
//
// Walks an N-dimensional view in row-major order, one element per input beat, and returns
// for each beat the strided address (base offset plus stride times position summed over
// the dimensions in use), the running compact index, the value to write and a last flag
// on the final element, after which the counters wrap. A beat is taken every cycle unless the
// input is stalled. The position counters and carry chain update at the accept edge, as the
// first stage register loads; the stride multiplies fill the second stage and the offset sum
// with the overflow check loads the output register. The three stages fill up while the
// output is stalled, so input stall rises only once all three hold a beat. The user must write
// configuration only while no beat is in flight; the block itself does not enforce this.
module strided_address_generator #(
    parameter int MAX_DIMS   = 4,
    parameter int ADDR_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sag_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sag_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    localparam int NUM_SLOTS = MAX_DIMS < sag_pkg::SLOTS ? MAX_DIMS : sag_pkg::SLOTS;

    sag_pkg::t_cfg        r_cfg;
    sag_pkg::t_adv        adv;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic [15:0]          s1_pos [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] s1_in_use;
    logic [31:0]          s1_index;
    logic [31:0]          s1_wval;
    logic                 s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= sag_pkg::RST_MODE;
            r_cfg.dim_count    <= sag_pkg::RST_DIM_COUNT;
            r_cfg.extent_words <= sag_pkg::RST_EXTENTS;
            r_cfg.stride_words <= sag_pkg::RST_STRIDES;
            r_cfg.base_offset  <= sag_pkg::RST_BASE;
            r_cfg.fill_value   <= sag_pkg::RST_FILL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sag_pkg::CFG_MODE:      r_cfg.mode         <= i_cfg_data[1:0];
                sag_pkg::CFG_DIM_COUNT: r_cfg.dim_count    <= i_cfg_data[2:0];
                sag_pkg::CFG_EXTENTS:   r_cfg.extent_words <= i_cfg_data;
                sag_pkg::CFG_STRIDES:   r_cfg.stride_words <= i_cfg_data;
                sag_pkg::CFG_BASE:      r_cfg.base_offset  <= i_cfg_data[31:0];
                sag_pkg::CFG_FILL:      r_cfg.fill_value   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its beat moves on
    always_comb begin
        adv.load3  = !r_v3 || !i_out_stall;
        adv.load2  = !r_v2 || adv.load3;
        adv.load1  = !r_v1 || adv.load2;
        adv.accept = i_in_valid && adv.load1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv.load1) begin
                r_v1 <= i_in_valid;
            end
            if (adv.load2) begin
                r_v2 <= r_v1;
            end
            if (adv.load3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_in_stall  = !adv.load1;
    assign o_out_valid = r_v3;

    sag_walk #(
        .MAX_DIMS(MAX_DIMS)
    ) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_adv    (adv),
        .i_beat   (i_in_data),
        .o_pos    (s1_pos),
        .o_in_use (s1_in_use),
        .o_index  (s1_index),
        .o_wval   (s1_wval),
        .o_last   (s1_last)
    );

    sag_addr #(
        .MAX_DIMS  (MAX_DIMS),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_addr (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .i_adv    (adv),
        .i_pos    (s1_pos),
        .i_in_use (s1_in_use),
        .i_index  (s1_index),
        .i_wval   (s1_wval),
        .i_last   (s1_last),
        .o_beat   (o_out_data)
    );

    // input stalls only with every stage holding a beat
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a free stage");

    // a restarted beat starts counting from zero
    a_restart_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv.accept && i_in_data.restart) |=> (s1_index == 32'd0))
        else $error("restart did not clear the element count");

    // a new output beat must come from a filled second stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(r_v2))
        else $error("output beat appeared from an empty stage");

endmodule
